@@ rtl/core/signed_int_to_decimal_ascii_top_defines.svh @@
// Assertion macros for the decimal ASCII converter RTL, used by the serializer.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_TOP_DEFINES_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication check.
`define SITDA_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sitda check failed");
// Next-cycle implication check.
`define SITDA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sitda check failed");
`else
`define SITDA_ASSERT_NOW(lbl, ante, cons)
`define SITDA_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

@@ rtl/core/sitda_pkg.sv @@
// Shared constants and helpers for the decimal ASCII converter.
package sitda_pkg;

    // ASCII codes, six bits wide
    localparam logic [5:0] CHAR_MINUS = 6'd45;
    localparam logic [5:0] CHAR_ZERO  = 6'd48;

    // Double-dabble iterations done per pipeline stage
    localparam int DABBLE_STEPS = 8;

    // BCD digit correction before each shift
    function automatic logic [3:0] add3(input logic [3:0] d);
        logic [3:0] r;
        r = (d >= 4'd5) ? (d + 4'd3) : d;
        return r;
    endfunction

endpackage

@@ rtl/core/sitda_dabble_stage.sv @@
// One registered stage of the pipelined binary-to-BCD conversion.
module sitda_dabble_stage
    import sitda_pkg::*;
#(
    parameter int MAG_W = 32,
    parameter int BCD_W = 40,
    parameter int STEPS = 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [MAG_W-1:0] in_mag,
    input  logic [BCD_W-1:0] in_bcd,
    input  logic             in_neg,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [MAG_W-1:0] out_mag,
    output logic [BCD_W-1:0] out_bcd,
    output logic             out_neg
);

    logic             valid_reg;
    logic [MAG_W-1:0] mag_reg;
    logic [BCD_W-1:0] bcd_reg;
    logic             neg_reg;
    logic [MAG_W-1:0] mag_next;
    logic [BCD_W-1:0] bcd_next;

    // STEPS iterations: correct every digit, then shift in the next bit
    always_comb
    begin
        mag_next = in_mag;
        bcd_next = in_bcd;
        for (int s = 0; s < STEPS; s++)
        begin
            for (int n = 0; n < BCD_W / 4; n++)
            begin
                bcd_next[4*n +: 4] = add3(bcd_next[4*n +: 4]);
            end
            bcd_next = {bcd_next[BCD_W-2:0], mag_next[MAG_W-1]};
            mag_next = {mag_next[MAG_W-2:0], 1'b0};
        end
    end

    assign in_ready = !valid_reg || out_ready;

    // valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            mag_reg <= mag_next;
            bcd_reg <= bcd_next;
            neg_reg <= in_neg;
        end
    end

    assign out_valid = valid_reg;
    assign out_mag   = mag_reg;
    assign out_bcd   = bcd_reg;
    assign out_neg   = neg_reg;

endmodule

@@ rtl/core/sitda_serializer.sv @@
// Emits sign and BCD digits as ASCII characters, one beat per cycle while out_ready is high.
`include "signed_int_to_decimal_ascii_top_defines.svh"
module sitda_serializer
    import sitda_pkg::*;
#(
    parameter int NDIG = 10
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [4*NDIG-1:0] in_bcd,
    input  logic              in_neg,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [5:0]        out_char,
    output logic              out_last
);

    localparam int IDX_W = $clog2(NDIG);

    logic             busy_reg;
    logic             busy_next;
    logic             sign_reg;
    logic             sign_next;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic [3:0]       digits_reg [NDIG];
    logic [IDX_W-1:0] lead;
    logic             load;
    logic             fire;

    // highest nonzero digit; zero keeps a single digit
    always_comb
    begin
        lead = '0;
        for (int i = 0; i < NDIG; i++)
        begin
            if (in_bcd[4*i +: 4] != 4'd0)
            begin
                lead = IDX_W'(i);
            end
        end
    end

    assign out_valid = busy_reg;
    assign out_last  = !sign_reg && (idx_reg == '0);
    assign out_char  = sign_reg ? CHAR_MINUS : (CHAR_ZERO + {2'b00, digits_reg[idx_reg]});
    assign fire      = out_valid && out_ready;
    assign in_ready  = !busy_reg || (out_ready && out_last);
    assign load      = in_valid && in_ready;

    // emit sequencing
    always_comb
    begin
        busy_next = busy_reg;
        sign_next = sign_reg;
        idx_next  = idx_reg;
        if (load)
        begin
            busy_next = 1'b1;
            sign_next = in_neg;
            idx_next  = lead;
        end
        else if (fire)
        begin
            if (sign_reg)
            begin
                sign_next = 1'b0;
            end
            else if (idx_reg == '0)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                idx_next = idx_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            sign_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            sign_reg <= sign_next;
            idx_reg  <= idx_next;
        end
    end

    // digit store
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int i = 0; i < NDIG; i++)
            begin
                digits_reg[i] <= in_bcd[4*i +: 4];
            end
        end
    end

    `SITDA_ASSERT_NOW(a_load_when_free, load, !busy_reg || (fire && out_last))
    `SITDA_ASSERT_NOW(a_sign_only_busy, sign_reg, busy_reg)
    `SITDA_ASSERT_NOW(a_digit_decimal, busy_reg && !sign_reg, digits_reg[idx_reg] <= 4'd9)
    `SITDA_ASSERT_NEXT(a_end_of_text, fire && out_last, busy_reg == $past(load))

endmodule

@@ rtl/core/signed_int_to_decimal_ascii_top.sv @@
// Throughput: input beats enter the conversion pipeline every cycle unless back-pressure
// stalls it; the output side sends one character per cycle while char_ready is high, so a
// value is 1 to 11 characters (sign plus digits). The character serializer at the end
// sets the sustained rate.
// Reset: rst_n is asynchronous, active low; it clears all valid bits and the emit state.
// Top level: signed integer to decimal ASCII character stream.
module signed_int_to_decimal_ascii_top
    import sitda_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          value_valid,
    output logic                          value_ready,
    input  logic signed [VALUE_WIDTH-1:0] value,
    output logic                          char_valid,
    input  logic                          char_ready,
    output logic [5:0]                    char_code,
    output logic                          last
);

    localparam int W      = VALUE_WIDTH;
    localparam int NDIG   = (W * 78) / 256 + 1;
    localparam int BCD_W  = 4 * NDIG;
    localparam int NSTAGE = (W + DABBLE_STEPS - 1) / DABBLE_STEPS;

    logic             st_valid [NSTAGE+1];
    logic             st_ready [NSTAGE+1];
    logic [W-1:0]     st_mag   [NSTAGE+1];
    logic [BCD_W-1:0] st_bcd   [NSTAGE+1];
    logic             st_neg   [NSTAGE+1];

    logic             in_valid_reg;
    logic [W-1:0]     in_mag_reg;
    logic             in_neg_reg;
    logic [W-1:0]     raw;
    logic [W-1:0]     mag_next;

    // magnitude, formed unsigned so the most negative value is exact
    assign raw      = value;
    assign mag_next = raw[W-1] ? ((~raw) + {{(W-1){1'b0}}, 1'b1}) : raw;

    assign value_ready = !in_valid_reg || st_ready[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (value_ready)
        begin
            in_valid_reg <= value_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (value_valid && value_ready)
        begin
            in_mag_reg <= mag_next;
            in_neg_reg <= raw[W-1];
        end
    end

    assign st_valid[0] = in_valid_reg;
    assign st_mag[0]   = in_mag_reg;
    assign st_bcd[0]   = '0;
    assign st_neg[0]   = in_neg_reg;

    // binary-to-BCD pipeline
    for (genvar i = 0; i < NSTAGE; i++)
    begin : g_dabble
        localparam int STEPS = ((W - DABBLE_STEPS * i) < DABBLE_STEPS) ?
                               (W - DABBLE_STEPS * i) : DABBLE_STEPS;
        sitda_dabble_stage #(
            .MAG_W (W),
            .BCD_W (BCD_W),
            .STEPS (STEPS)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (st_valid[i]),
            .in_ready  (st_ready[i]),
            .in_mag    (st_mag[i]),
            .in_bcd    (st_bcd[i]),
            .in_neg    (st_neg[i]),
            .out_valid (st_valid[i+1]),
            .out_ready (st_ready[i+1]),
            .out_mag   (st_mag[i+1]),
            .out_bcd   (st_bcd[i+1]),
            .out_neg   (st_neg[i+1])
        );
    end

    // character output
    sitda_serializer #(
        .NDIG (NDIG)
    ) u_ser (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (st_valid[NSTAGE]),
        .in_ready  (st_ready[NSTAGE]),
        .in_bcd    (st_bcd[NSTAGE]),
        .in_neg    (st_neg[NSTAGE]),
        .out_valid (char_valid),
        .out_ready (char_ready),
        .out_char  (char_code),
        .out_last  (last)
    );

endmodule
